// ===== design/laplacian_edge_threshold_assert.svh =====
// ----------------------------------------------------------------------------
// laplacian edge threshold assertion macros
// concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef LAPLACIAN_EDGE_THRESHOLD_ASSERT_SVH
`define LAPLACIAN_EDGE_THRESHOLD_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked on every rising edge outside reset
`define LAPEDGE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define LAPEDGE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LAPEDGE_ASSERT(label, clk, rst_n, prop, msg)
`define LAPEDGE_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== design/lapedge_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lapedge_pkg
// types, constants and the channel response function of the edge detector
// ----------------------------------------------------------------------------
package lapedge_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    // column index, effective size and row counter widths
    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int SIZE_W = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);

    // configuration register widths
    localparam int CFG_SIZE_W = 12;
    localparam int CFG_THR_W  = 8;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;

    localparam int CHAN_W = 8;
    localparam int PIX_W  = 3 * CHAN_W;
    // one line store entry: row above in the upper half, centre row below
    localparam int MEM_W  = 2 * PIX_W;

    localparam logic [CFG_SIZE_W-1:0] FRAME_WIDTH_RST    = CFG_SIZE_W'(640);
    localparam logic [CFG_SIZE_W-1:0] FRAME_HEIGHT_RST   = CFG_SIZE_W'(480);
    localparam logic [CFG_THR_W-1:0]  EDGE_THRESHOLD_RST = CFG_THR_W'(26);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH    = 2'd0,
        REG_FRAME_HEIGHT   = 2'd1,
        REG_EDGE_THRESHOLD = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic              req_type;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_lapedge_in;

    typedef struct packed {
        logic edge_res;
        logic frame_last;
    } t_lapedge_out;

    // work carried from the read stage to the compute stage
    typedef struct packed {
        logic             res;
        logic             wr;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] px;
        logic             up_c;
        logic             left_c;
        logic             right_c;
        logic             down_c;
        logic             last;
    } t_lapedge_s1;

    // any channel of 4c - u - l - d - r, clamped to 0..255, above thr
    function automatic logic edge_of(
        input logic [PIX_W-1:0]     c,
        input logic [PIX_W-1:0]     u,
        input logic [PIX_W-1:0]     l,
        input logic [PIX_W-1:0]     d,
        input logic [PIX_W-1:0]     r,
        input logic [CFG_THR_W-1:0] thr
    );
        logic signed [10:0] v;
        logic [CHAN_W-1:0]  clamp;
        logic               hit;
        hit = 1'b0;
        for (int k = 0; k < 3; k++) begin
            v = signed'({1'b0, c[k*CHAN_W +: CHAN_W], 2'b00})
              - signed'({3'b000, u[k*CHAN_W +: CHAN_W]})
              - signed'({3'b000, l[k*CHAN_W +: CHAN_W]})
              - signed'({3'b000, d[k*CHAN_W +: CHAN_W]})
              - signed'({3'b000, r[k*CHAN_W +: CHAN_W]});
            clamp = (v[9:8] != 2'b00) ? {CHAN_W{1'b1}} : v[7:0];
            if (!v[10] && (clamp > thr)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

// ===== design/lapedge_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lapedge_ram
// one write port, two registered read ports, read before write
// ----------------------------------------------------------------------------
module lapedge_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]                       o_rdata_a,
    output logic [WIDTH-1:0]                       o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

// ===== design/laplacian_edge_threshold.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laplacian_edge_threshold
// 3x3 cross laplacian edge detector on a raster-order rgb pixel stream
// ----------------------------------------------------------------------------
// Pixel items enter on i_valid/i_data and are taken when o_stall is low.
// Results leave on o_valid/o_data and are taken when i_stall is low.
// A pixel at row r, column c produces the result for row r-1, column c;
// pixels of the first row produce nothing. Once the last row is in, one
// drain item per column flushes the final row; its last result carries
// frame_last and restarts the frame.
// Throughput is one item per clock while o_stall is low. A taken item is
// registered into the compute stage: the line store is read at the
// accepting edge, then the response is computed and the store written
// back as the compute stage advances and its result enters the output register.
// Both line stores share one memory with a registered read, read at the
// item's column and the next one; back-to-back writes to a column being
// read are forwarded.
// Reset restores the register defaults (640 x 480, threshold 26) and
// clears the frame position; the memory is not cleared. Writing the frame
// width or height also restarts the frame.
// A stalled result holds the output register; the compute stage keeps
// taking items that give no result and otherwise holds, which stalls input.
// ----------------------------------------------------------------------------
`include "laplacian_edge_threshold_assert.svh"

module laplacian_edge_threshold (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  lapedge_pkg::t_lapedge_in               i_data,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output lapedge_pkg::t_lapedge_out              o_data,
    input  logic                                   i_cfg_we,
    input  logic [lapedge_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lapedge_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import lapedge_pkg::*;

    // configuration
    logic [CFG_SIZE_W-1:0] r_frame_width;
    logic [CFG_SIZE_W-1:0] r_frame_height;
    logic [CFG_THR_W-1:0]  r_edge_threshold;
    logic [SIZE_W-1:0]     w_eff;
    logic [ROW_W-1:0]      h_eff;

    // positions
    logic [COL_W-1:0] r_in_col, n_in_col;
    logic [ROW_W-1:0] r_in_row, n_in_row;
    logic [COL_W-1:0] r_out_col, n_out_col;

    // read stage
    logic              accept;
    logic              guard;
    logic [COL_W-1:0]  g_in_col;
    logic [ROW_W-1:0]  g_in_row;
    logic [COL_W-1:0]  g_out_col;
    logic              is_drain;
    logic              rows_done;
    logic              work;
    logic [COL_W-1:0]  col;
    logic [SIZE_W-1:0] col_p1;
    logic [COL_W-1:0]  raddr_b;
    t_lapedge_s1       n_s1;

    // compute stage
    logic              r_s1_vld;
    t_lapedge_s1       r_s1;
    logic              s1_go;
    logic              s1_wr;
    logic [MEM_W-1:0]  ram_a;
    logic [MEM_W-1:0]  ram_b;
    logic [MEM_W-1:0]  rd_a;
    logic [MEM_W-1:0]  rd_b;
    logic [PIX_W-1:0]  centre;
    logic [PIX_W-1:0]  up_px;
    logic [PIX_W-1:0]  left_px;
    logic [PIX_W-1:0]  right_px;
    logic [PIX_W-1:0]  down_px;
    logic [MEM_W-1:0]  wdata;
    logic              edge_hit;
    logic [PIX_W-1:0]  r_left;

    // forwarding of the write that lands on the edge of a read
    logic             r_fwd_a;
    logic             r_fwd_b;
    logic [MEM_W-1:0] r_fwd_data;

    // output register
    logic         r_out_vld;
    t_lapedge_out r_out;

    // effective frame size: zero counts as one, clipped to the maximum
    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = SIZE_W'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w_eff = SIZE_W'(MAX_WIDTH);
        end else begin
            w_eff = SIZE_W'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h_eff = ROW_W'(1);
        end else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) begin
            h_eff = ROW_W'(MAX_HEIGHT);
        end else begin
            h_eff = ROW_W'(r_frame_height);
        end
    end

    // handshakes
    always_comb begin
        s1_go   = r_s1_vld && (!r_s1.res || !r_out_vld || !i_stall);
        s1_wr   = s1_go && r_s1.wr;
        o_stall = r_s1_vld && !s1_go;
        accept  = i_valid && !o_stall;
    end

    // read stage: position bookkeeping and store read addresses
    always_comb begin
        guard = (SIZE_W'(r_in_col) >= w_eff) || (SIZE_W'(r_out_col) >= w_eff)
             || (r_in_row > h_eff);
        g_in_col  = guard ? '0 : r_in_col;
        g_in_row  = guard ? '0 : r_in_row;
        g_out_col = guard ? '0 : r_out_col;

        is_drain  = i_data.req_type;
        rows_done = g_in_row >= h_eff;
        work      = is_drain ? rows_done : !rows_done;
        col       = is_drain ? g_out_col : g_in_col;
        col_p1    = SIZE_W'(col) + SIZE_W'(1);
        raddr_b   = col_p1[COL_W-1:0];

        n_s1.res     = is_drain || (g_in_row != '0);
        n_s1.wr      = !is_drain;
        n_s1.col     = col;
        n_s1.px      = {i_data.red, i_data.green, i_data.blue};
        n_s1.up_c    = is_drain ? (h_eff == ROW_W'(1)) : (g_in_row < ROW_W'(2));
        n_s1.left_c  = col == '0;
        n_s1.right_c = col_p1 >= w_eff;
        n_s1.down_c  = is_drain;
        n_s1.last    = is_drain && (col_p1 >= w_eff);

        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        if (accept) begin
            n_in_col  = g_in_col;
            n_in_row  = g_in_row;
            n_out_col = g_out_col;
            if (work && !is_drain) begin
                if (SIZE_W'(g_in_col) + SIZE_W'(1) >= w_eff) begin
                    n_in_col = '0;
                    n_in_row = g_in_row + ROW_W'(1);
                end else begin
                    n_in_col = g_in_col + COL_W'(1);
                end
                if (n_s1.res) begin
                    if (SIZE_W'(g_out_col) + SIZE_W'(1) >= w_eff) begin
                        n_out_col = '0;
                    end else begin
                        n_out_col = g_out_col + COL_W'(1);
                    end
                end
            end else if (work) begin
                if (n_s1.last) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                end else begin
                    n_out_col = g_out_col + COL_W'(1);
                end
            end
        end
        if (i_cfg_we && ((i_cfg_idx == REG_FRAME_WIDTH) || (i_cfg_idx == REG_FRAME_HEIGHT))) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width    <= FRAME_WIDTH_RST;
            r_frame_height   <= FRAME_HEIGHT_RST;
            r_edge_threshold <= EDGE_THRESHOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_WIDTH:    r_frame_width    <= i_cfg_data[CFG_SIZE_W-1:0];
                REG_FRAME_HEIGHT:   r_frame_height   <= i_cfg_data[CFG_SIZE_W-1:0];
                REG_EDGE_THRESHOLD: r_edge_threshold <= i_cfg_data[CFG_THR_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
        end
    end

    // both line stores in one entry per column
    lapedge_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_we      (s1_wr),
        .i_waddr   (r_s1.col),
        .i_wdata   (wdata),
        .i_re      (accept),
        .i_raddr_a (col),
        .i_raddr_b (raddr_b),
        .o_rdata_a (ram_a),
        .o_rdata_b (ram_b)
    );

    // compute stage
    always_comb begin
        rd_a     = r_fwd_a ? r_fwd_data : ram_a;
        rd_b     = r_fwd_b ? r_fwd_data : ram_b;
        centre   = rd_a[PIX_W-1:0];
        up_px    = r_s1.up_c    ? centre : rd_a[MEM_W-1:PIX_W];
        left_px  = r_s1.left_c  ? centre : r_left;
        right_px = r_s1.right_c ? centre : rd_b[PIX_W-1:0];
        down_px  = r_s1.down_c  ? centre : r_s1.px;
        // old centre row moves up, new pixel becomes the centre row
        wdata    = {centre, r_s1.px};
        edge_hit = edge_of(centre, up_px, left_px, down_px, right_px, r_edge_threshold);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_go || !r_s1_vld) begin
            r_s1_vld <= accept && work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1       <= n_s1;
            r_fwd_a    <= s1_wr && (col == r_s1.col);
            r_fwd_b    <= s1_wr && (raddr_b == r_s1.col);
            r_fwd_data <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (s1_go && r_s1.res) begin
            r_left <= centre;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_go && r_s1.res) begin
            r_out_vld <= 1'b1;
        end else if (r_out_vld && !i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1.res) begin
            r_out.edge_res   <= edge_hit;
            r_out.frame_last <= r_s1.last;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    `LAPEDGE_ASSERT(a_last_restarts_frame, i_clk, i_rst_n, (accept && work && n_s1.last) |=> ((r_in_col == '0) && (r_in_row == '0) && (r_out_col == '0)), "frame_last item did not restart the frame")
    `LAPEDGE_ASSERT(a_result_reaches_output, i_clk, i_rst_n, (s1_go && r_s1.res) |=> r_out_vld, "result left compute stage but output register is empty")
    `LAPEDGE_ASSERT(a_row_in_range, i_clk, i_rst_n, r_in_row <= h_eff, "input row counter ran past frame height")

endmodule
